// ===== hw/rtl/bpb_pkg.sv =====
// Package for the bimodal branch predictor with tag-only branch target buffer.
// Holds the input and result word types, field widths and predictor constants.
// No dependencies.
package bpb_pkg;

  // Field widths of the input and result words
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned PIDX_FIELD_W = 10;
  localparam int unsigned BIDX_FIELD_W = 8;
  localparam int unsigned TAG_FIELD_W  = 22;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned CTR_W        = 2;

  // Default table sizes
  localparam int unsigned PRED_ENTRIES_DEF = 1024;
  localparam int unsigned BTB_ENTRIES_DEF  = 256;

  // Byte offset bits below the word address
  localparam int unsigned WORD_OFS_W = 2;

  // Counter encodings: reset value is weakly not taken
  localparam logic [CTR_W-1:0] CTR_RESET_VAL = 2'd1;
  localparam logic [CTR_W-1:0] CTR_MIN       = 2'd0;
  localparam logic [CTR_W-1:0] CTR_MAX       = 2'd3;

  // Branch record presented on start
  typedef struct packed {
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] target_address;
    logic              taken;
    logic              is_conditional;
  } in_word_t;

  // Result word, one per accepted record
  typedef struct packed {
    logic                    handled;
    logic [PIDX_FIELD_W-1:0] pred_index;
    logic [CTR_W-1:0]        counter_before;
    logic [CTR_W-1:0]        counter_after;
    logic                    predicted_taken;
    logic                    mispredicted;
    logic [BIDX_FIELD_W-1:0] btb_index;
    logic [TAG_FIELD_W-1:0]  btb_tag_after;
    logic                    btb_hit;
    logic                    forward;
    logic [CNT_W-1:0]        btb_lookups_total;
    logic [CNT_W-1:0]        btb_misses_total;
  } out_word_t;

endpackage

// ===== hw/rtl/bpb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// A read and a write to the same address in one cycle return the old data.
// No dependencies.
module bpb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first storage array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bimodal_branch_predictor_btb.sv =====
// Bimodal branch predictor with a tag-only branch target buffer.
// An accepted word passes through stage one and then the output register to out_word with out_valid.
// Throughput: one word per cycle while not busy; the tables are read and rewritten through one RAM pass.
// Reset: a clearing pass over max(pred, BTB index range) entries (1024 by default) holds busy.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Depends on bpb_pkg and bpb_ram.
module bimodal_branch_predictor_btb
  import bpb_pkg::*;
#(
  parameter int unsigned PRED_ENTRIES = PRED_ENTRIES_DEF,
  parameter int unsigned BTB_ENTRIES  = BTB_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  // Index widths use floor(log2(entries)) address bits
  localparam int unsigned PRED_IDX_W = $clog2(PRED_ENTRIES + 1) - 1;
  localparam int unsigned BTB_IDX_W  = $clog2(BTB_ENTRIES + 1) - 1;
  localparam int unsigned PRED_DEPTH = 2 ** PRED_IDX_W;
  localparam int unsigned BTB_DEPTH  = 2 ** BTB_IDX_W;
  localparam int unsigned TAG_W      = ADDR_W - BTB_IDX_W - WORD_OFS_W;
  localparam int unsigned BTB_W      = TAG_W + 1;
  localparam int unsigned CLR_DEPTH  = (PRED_DEPTH > BTB_DEPTH) ? PRED_DEPTH : BTB_DEPTH;
  localparam int unsigned CLR_W      = $clog2(CLR_DEPTH) + 1;

  // Control and pipeline registers
  logic                  clearing_r;
  logic [CLR_W-1:0]      clr_cnt_r;
  logic                  s1_valid_r;
  in_word_t              s1_word_r;
  logic                  out_valid_r;
  out_word_t             out_word_r;
  logic [CNT_W-1:0]      hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]      miss_cnt_r, miss_cnt_nxt;

  // Forwarding of the last table writes
  logic                  fwd_ctr_v_r;
  logic [PRED_IDX_W-1:0] fwd_pidx_r;
  logic [CTR_W-1:0]      fwd_ctr_r;
  logic                  fwd_btb_v_r;
  logic [BTB_IDX_W-1:0]  fwd_bidx_r;
  logic [TAG_W-1:0]      fwd_tag_r;

  // RAM ports
  logic                  ctr_we;
  logic [PRED_IDX_W-1:0] ctr_waddr;
  logic [CTR_W-1:0]      ctr_wdata;
  logic [PRED_IDX_W-1:0] ctr_raddr;
  logic [CTR_W-1:0]      ctr_rdata;
  logic                  btb_we;
  logic [BTB_IDX_W-1:0]  btb_waddr;
  logic [BTB_W-1:0]      btb_wdata;
  logic [BTB_IDX_W-1:0]  btb_raddr;
  logic [BTB_W-1:0]      btb_rdata;

  // Stage one decode
  logic                  accept;
  logic [PRED_IDX_W-1:0] pidx;
  logic [BTB_IDX_W-1:0]  bidx;
  logic [TAG_W-1:0]      tag;
  logic [CTR_W-1:0]      ctr_before;
  logic [CTR_W-1:0]      ctr_after;
  logic                  ent_valid;
  logic [TAG_W-1:0]      ent_tag;
  logic [TAG_W-1:0]      tag_after;
  logic                  pred;
  logic                  hit;
  logic                  handled;
  logic                  btb_upd;
  logic [ADDR_W-1:0]     pidx_ext;
  logic [ADDR_W-1:0]     bidx_ext;
  logic [ADDR_W-1:0]     tag_ext;
  out_word_t             out_word_nxt;

  assign busy   = clearing_r;
  assign accept = start && !busy;

  // Table reads are issued straight from the incoming word
  assign ctr_raddr = in_word.pc[PRED_IDX_W+WORD_OFS_W-1:WORD_OFS_W];
  assign btb_raddr = in_word.pc[BTB_IDX_W+WORD_OFS_W-1:WORD_OFS_W];

  // Index and tag of the word in stage one
  assign pidx = s1_word_r.pc[PRED_IDX_W+WORD_OFS_W-1:WORD_OFS_W];
  assign bidx = s1_word_r.pc[BTB_IDX_W+WORD_OFS_W-1:WORD_OFS_W];
  assign tag  = s1_word_r.pc[ADDR_W-1:BTB_IDX_W+WORD_OFS_W];

  // Counter and BTB entry, bypassing the write made in the previous cycle
  always_comb begin
    if (fwd_ctr_v_r && (fwd_pidx_r == pidx)) begin
      ctr_before = fwd_ctr_r;
    end else begin
      ctr_before = ctr_rdata;
    end
    if (fwd_btb_v_r && (fwd_bidx_r == bidx)) begin
      ent_valid = 1'b1;
      ent_tag   = fwd_tag_r;
    end else begin
      ent_valid = btb_rdata[BTB_W-1];
      ent_tag   = btb_rdata[TAG_W-1:0];
    end
  end

  // Prediction, saturating update and BTB outcome
  always_comb begin
    handled = s1_valid_r && s1_word_r.is_conditional;
    btb_upd = handled && s1_word_r.taken;
    pred    = ctr_before[CTR_W-1];
    hit     = pred && ent_valid && (ent_tag == tag);
    if (s1_word_r.taken) begin
      ctr_after = (ctr_before == CTR_MAX) ? CTR_MAX : ctr_before + 2'd1;
    end else begin
      ctr_after = (ctr_before == CTR_MIN) ? CTR_MIN : ctr_before - 2'd1;
    end
    tag_after    = s1_word_r.taken ? tag : ent_tag;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (handled && pred) begin
      if (hit) begin
        hit_cnt_nxt = hit_cnt_r + 32'd1;
      end else begin
        miss_cnt_nxt = miss_cnt_r + 32'd1;
      end
    end
  end

  // Result word; an unconditional record gives all zero fields
  assign pidx_ext = ADDR_W'(pidx);
  assign bidx_ext = ADDR_W'(bidx);
  assign tag_ext  = ADDR_W'(tag_after);

  always_comb begin
    out_word_nxt = '0;
    if (handled) begin
      out_word_nxt.handled           = 1'b1;
      out_word_nxt.pred_index        = pidx_ext[PIDX_FIELD_W-1:0];
      out_word_nxt.counter_before    = ctr_before;
      out_word_nxt.counter_after     = ctr_after;
      out_word_nxt.predicted_taken   = pred;
      out_word_nxt.mispredicted      = pred != s1_word_r.taken;
      out_word_nxt.btb_index         = bidx_ext[BIDX_FIELD_W-1:0];
      out_word_nxt.btb_tag_after     = tag_ext[TAG_FIELD_W-1:0];
      out_word_nxt.btb_hit           = hit;
      out_word_nxt.forward           = s1_word_r.pc < s1_word_r.target_address;
      out_word_nxt.btb_lookups_total = hit_cnt_nxt + miss_cnt_nxt;
      out_word_nxt.btb_misses_total  = miss_cnt_nxt;
    end
  end

  // Table writes: the clearing pass after reset, then updates from stage one
  always_comb begin
    if (clearing_r) begin
      ctr_we    = clr_cnt_r < CLR_W'(PRED_DEPTH);
      ctr_waddr = clr_cnt_r[PRED_IDX_W-1:0];
      ctr_wdata = CTR_RESET_VAL;
      btb_we    = clr_cnt_r < CLR_W'(BTB_DEPTH);
      btb_waddr = clr_cnt_r[BTB_IDX_W-1:0];
      btb_wdata = '0;
    end else begin
      ctr_we    = handled;
      ctr_waddr = pidx;
      ctr_wdata = ctr_after;
      btb_we    = btb_upd;
      btb_waddr = bidx;
      btb_wdata = {1'b1, tag};
    end
  end

  bpb_ram #(
    .WIDTH (CTR_W),
    .DEPTH (PRED_DEPTH)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  bpb_ram #(
    .WIDTH (BTB_W),
    .DEPTH (BTB_DEPTH)
  ) u_btb_ram (
    .clk   (clk),
    .we    (btb_we),
    .waddr (btb_waddr),
    .wdata (btb_wdata),
    .raddr (btb_raddr),
    .rdata (btb_rdata)
  );

  // Control state: clearing pass, valid flags, totals and bypass flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      fwd_ctr_v_r <= 1'b0;
      fwd_btb_v_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + CLR_W'(1);
        if (clr_cnt_r == CLR_W'(CLR_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      fwd_ctr_v_r <= handled;
      fwd_btb_v_r <= btb_upd;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= in_word;
    end
    out_word_r <= out_word_nxt;
    fwd_pidx_r <= pidx;
    fwd_ctr_r  <= ctr_after;
    fwd_bidx_r <= bidx;
    fwd_tag_r  <= tag;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // No word is in flight and no bypass is armed while the tables are cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!s1_valid_r && !fwd_ctr_v_r && !fwd_btb_v_r))
    else $error("word in flight during clearing pass");

  // An unconditional record gives an all-zero result
  a_unhandled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.handled) |-> (out_word_r == '0))
    else $error("unhandled record with non-zero result");

  // A BTB hit needs a taken prediction
  a_hit_pred: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.btb_hit) |-> out_word_r.predicted_taken)
    else $error("BTB hit without taken prediction");

  // The miss total moves by at most one per cycle
  a_miss_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((miss_cnt_r == $past(miss_cnt_r)) ||
                      (miss_cnt_r == $past(miss_cnt_r) + 32'd1)))
    else $error("miss total jumped");

  // A BTB update leaves the stored tag equal to the reported one
  a_taken_tag: assert property (@(posedge clk) disable iff (!rst_n)
    btb_upd |-> (tag_after == tag))
    else $error("taken branch reports stale tag");

endmodule
